[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
// Depends on nothing; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define NPLE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define NPLE_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/nple_pkg.sv]
// Types, widths and codes of the packet latency estimator.
// No dependencies; imported by every module of the block.
package nple_pkg;

  localparam int NODE_W     = 16;
  localparam int SIZE_W     = 20;
  localparam int NUM_W      = 24;
  localparam int TOPO_W     = 2;
  localparam int RAD_W      = 5;
  localparam int DIM_W      = 3;
  localparam int DLY_W      = 4;
  localparam int STD_W      = 5;
  localparam int FB_W       = 11;
  localparam int HEAD_W     = 7;
  localparam int BODY_W     = 6;
  localparam int HOP_W      = 16;
  localparam int FLIT_W     = 24;
  localparam int LAT_W      = 32;
  localparam int DCNT_W     = 4;
  localparam int BPS        = 4;
  localparam int FLIT_STG   = NUM_W / BPS;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int QDEPTH     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TOPOLOGY_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSIONS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUTING_DLY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VC_ALLOC_DLY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SW_ALLOC_DLY  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SW_TRAV_DLY   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIT_BITS     = 3'd7;

  localparam logic [TOPO_W-1:0] TOPO_MESH  = 2'd0;
  localparam logic [TOPO_W-1:0] TOPO_TORUS = 2'd1;
  localparam logic [TOPO_W-1:0] TOPO_OTHER = 2'd2;

  typedef struct packed {
    logic [TOPO_W-1:0] topo;
    logic [RAD_W-1:0]  radix;
    logic [DIM_W-1:0]  dims;
    logic [HEAD_W-1:0] head_p1;
    logic [BODY_W-1:0] body;
    logic [FB_W-1:0]   fb;
  } cfg_t;

  typedef struct packed {
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [HOP_W-1:0]  lin_hops;
    logic [DCNT_W-1:0] dims_use;
    logic [NUM_W-1:0]  num;
    logic              one;
  } item_t;

  // number of divider stages in the back end
  function automatic int pipe_depth(int max_dims, int id_bits);
    int idw;
    int hst;
    idw = (id_bits < NODE_W) ? id_bits : NODE_W;
    hst = max_dims * ((idw + BPS - 1) / BPS);
    return (hst > FLIT_STG) ? hst : FLIT_STG;
  endfunction

endpackage

[hdl/nple_front.sv]
// Front end: masks node ids, classifies topology and packet, builds the queue entry.
// Depends on nple_pkg.
module nple_front import nple_pkg::*; #(
  parameter int MAX_DIMS     = 4,
  parameter int NODE_ID_BITS = 16
) (
  input  logic              start,
  input  logic              full,
  input  logic [NODE_W-1:0] in_source_node,
  input  logic [NODE_W-1:0] in_dest_node,
  input  logic [SIZE_W-1:0] in_size_bytes,
  input  logic              in_is_reply,
  input  cfg_t              cfg,
  output logic              push,
  output item_t             item
);

  localparam int ID_W = (NODE_ID_BITS < NODE_W) ? NODE_ID_BITS : NODE_W;
  localparam logic [NODE_W-1:0] ID_MASK = {NODE_W{1'b1}} >> (NODE_W - ID_W);

  logic [NODE_W-1:0] src_m;
  logic [NODE_W-1:0] dst_m;
  logic              linear;
  logic [DCNT_W-1:0] dims_clamp;

  assign push   = start && !full;
  assign src_m  = in_source_node & ID_MASK;
  assign dst_m  = in_dest_node & ID_MASK;
  assign linear = (cfg.topo >= TOPO_OTHER);

  always_comb begin
    dims_clamp = DCNT_W'(cfg.dims);
    if (DCNT_W'(cfg.dims) > DCNT_W'(MAX_DIMS)) dims_clamp = DCNT_W'(MAX_DIMS);
  end

  always_comb begin
    item.src      = src_m;
    item.dst      = dst_m;
    item.lin_hops = '0;
    if (linear) begin
      item.lin_hops = (src_m > dst_m) ? HOP_W'(src_m - dst_m) : HOP_W'(dst_m - src_m);
    end
    item.dims_use = (linear || cfg.radix < RAD_W'(2)) ? '0 : dims_clamp;
    item.num      = NUM_W'({in_size_bytes, 3'b000}) + NUM_W'(cfg.fb) - NUM_W'(1);
    item.one      = in_is_reply || (in_size_bytes == '0);
  end

endmodule

[hdl/nple_queue.sv]
// Short queue between front and back end.
// Depends on nple_pkg (item_t, QDEPTH).
module nple_queue import nple_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_data,
  input  logic  pop,
  output logic  empty,
  output logic  full,
  output item_t head
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  item_t              mem_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_pop;

  assign empty  = (count_r == '0);
  assign full   = (count_r == CNT_W'(QDEPTH));
  assign head   = mem_r[rd_ptr_r];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      case ({push, do_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[hdl/nple_back.sv]
// Back end: per-dimension radix divider stages, flit divider, latency multiply and add.
// Depends on nple_pkg.
module nple_back import nple_pkg::*; #(
  parameter int MAX_DIMS     = 4,
  parameter int NODE_ID_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  item_t             in_item,
  input  cfg_t              cfg,
  output logic              out_valid,
  output logic [LAT_W-1:0]  out_latency_cycles,
  output logic [HOP_W-1:0]  out_hop_count,
  output logic [FLIT_W-1:0] out_flit_count
);

  localparam int ID_W = (NODE_ID_BITS < NODE_W) ? NODE_ID_BITS : NODE_W;
  localparam int HS   = (ID_W + BPS - 1) / BPS;
  localparam int ID_P = HS * BPS;
  localparam int HST  = MAX_DIMS * HS;
  localparam int FST  = FLIT_STG;
  localparam int L    = pipe_depth(MAX_DIMS, NODE_ID_BITS);
  localparam int PH_W = HOP_W + HEAD_W;
  localparam int PF_W = FLIT_W + BODY_W;

  // stage inputs
  logic              st_vld  [L];
  logic [ID_P-1:0]   st_a    [L];
  logic [ID_P-1:0]   st_b    [L];
  logic [RAD_W-1:0]  st_ra   [L];
  logic [RAD_W-1:0]  st_rb   [L];
  logic [HOP_W-1:0]  st_hop  [L];
  logic [NUM_W-1:0]  st_fq   [L];
  logic [FB_W-1:0]   st_fr   [L];
  logic              st_one  [L];
  logic [DCNT_W-1:0] st_dims [L];

  // stage results
  logic [ID_P-1:0]   a_nxt   [L];
  logic [ID_P-1:0]   b_nxt   [L];
  logic [RAD_W-1:0]  ra_nxt  [L];
  logic [RAD_W-1:0]  rb_nxt  [L];
  logic [HOP_W-1:0]  hop_nxt [L];
  logic [NUM_W-1:0]  fq_nxt  [L];
  logic [FB_W-1:0]   fr_nxt  [L];

  logic              vld_r   [L];
  logic [ID_P-1:0]   a_r     [L];
  logic [ID_P-1:0]   b_r     [L];
  logic [RAD_W-1:0]  ra_r    [L];
  logic [RAD_W-1:0]  rb_r    [L];
  logic [HOP_W-1:0]  hop_r   [L];
  logic [NUM_W-1:0]  fq_r    [L];
  logic [FB_W-1:0]   fr_r    [L];
  logic              one_r   [L];
  logic [DCNT_W-1:0] dims_r  [L];

  for (genvar k = 0; k < L; k++) begin : g_stage
    logic [ID_P-1:0]  a;
    logic [ID_P-1:0]  b;
    logic [RAD_W-1:0] ra;
    logic [RAD_W-1:0] rb;
    logic [RAD_W:0]   ta;
    logic [RAD_W:0]   tb;
    logic [RAD_W-1:0] d;
    logic [HOP_W-1:0] hop;
    logic [NUM_W-1:0] fq;
    logic [FB_W-1:0]  fr;
    logic [FB_W:0]    tf;

    if (k == 0) begin : g_first
      assign st_vld[k]  = in_valid;
      assign st_a[k]    = ID_P'(in_item.src[ID_W-1:0]);
      assign st_b[k]    = ID_P'(in_item.dst[ID_W-1:0]);
      assign st_ra[k]   = '0;
      assign st_rb[k]   = '0;
      assign st_hop[k]  = in_item.lin_hops;
      assign st_fq[k]   = in_item.num;
      assign st_fr[k]   = '0;
      assign st_one[k]  = in_item.one;
      assign st_dims[k] = in_item.dims_use;
    end else begin : g_next
      assign st_vld[k]  = vld_r[k-1];
      assign st_a[k]    = a_r[k-1];
      assign st_b[k]    = b_r[k-1];
      assign st_ra[k]   = ra_r[k-1];
      assign st_rb[k]   = rb_r[k-1];
      assign st_hop[k]  = hop_r[k-1];
      assign st_fq[k]   = fq_r[k-1];
      assign st_fr[k]   = fr_r[k-1];
      assign st_one[k]  = one_r[k-1];
      assign st_dims[k] = dims_r[k-1];
    end

    always_comb begin
      a   = st_a[k];
      b   = st_b[k];
      ra  = st_ra[k];
      rb  = st_rb[k];
      hop = st_hop[k];
      fq  = st_fq[k];
      fr  = st_fr[k];
      ta  = '0;
      tb  = '0;
      tf  = '0;
      d   = '0;
      if (k < HST) begin
        for (int i = 0; i < BPS; i++) begin
          ta = {ra, a[ID_P-1]};
          tb = {rb, b[ID_P-1]};
          a  = {a[ID_P-2:0], 1'b0};
          b  = {b[ID_P-2:0], 1'b0};
          if (ta >= {1'b0, cfg.radix}) begin
            ra   = ta[RAD_W-1:0] - cfg.radix;
            a[0] = 1'b1;
          end else begin
            ra = ta[RAD_W-1:0];
          end
          if (tb >= {1'b0, cfg.radix}) begin
            rb   = tb[RAD_W-1:0] - cfg.radix;
            b[0] = 1'b1;
          end else begin
            rb = tb[RAD_W-1:0];
          end
        end
        // last stage of a dimension: remainders are the coordinates
        if ((k % HS) == HS - 1) begin
          d = (ra > rb) ? ra - rb : rb - ra;
          if (cfg.topo == TOPO_TORUS && (cfg.radix - d) < d) d = cfg.radix - d;
          if (DCNT_W'(k / HS) < st_dims[k]) hop = hop + HOP_W'(d);
          ra = '0;
          rb = '0;
        end
      end
      if (k < FST) begin
        for (int i = 0; i < BPS; i++) begin
          tf = {fr, fq[NUM_W-1]};
          fq = {fq[NUM_W-2:0], 1'b0};
          if (tf >= {1'b0, cfg.fb}) begin
            fr    = tf[FB_W-1:0] - cfg.fb;
            fq[0] = 1'b1;
          end else begin
            fr = tf[FB_W-1:0];
          end
        end
      end
      a_nxt[k]   = a;
      b_nxt[k]   = b;
      ra_nxt[k]  = ra;
      rb_nxt[k]  = rb;
      hop_nxt[k] = hop;
      fq_nxt[k]  = fq;
      fr_nxt[k]  = fr;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k] <= 1'b0;
      else vld_r[k] <= st_vld[k];
    end

    always_ff @(posedge clk) begin
      a_r[k]    <= a_nxt[k];
      b_r[k]    <= b_nxt[k];
      ra_r[k]   <= ra_nxt[k];
      rb_r[k]   <= rb_nxt[k];
      hop_r[k]  <= hop_nxt[k];
      fq_r[k]   <= fq_nxt[k];
      fr_r[k]   <= fr_nxt[k];
      one_r[k]  <= st_one[k];
      dims_r[k] <= st_dims[k];
    end
  end

  // multiply stage
  logic [FLIT_W-1:0] flits;
  logic              m_vld_r;
  logic [PH_W-1:0]   m_ph_r;
  logic [PF_W-1:0]   m_pf_r;
  logic [HOP_W-1:0]  m_hop_r;
  logic [FLIT_W-1:0] m_flit_r;

  assign flits = one_r[L-1] ? FLIT_W'(1) : FLIT_W'(fq_r[L-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) m_vld_r <= 1'b0;
    else m_vld_r <= vld_r[L-1];
  end

  always_ff @(posedge clk) begin
    m_ph_r   <= PH_W'(hop_r[L-1]) * PH_W'(cfg.head_p1);
    m_pf_r   <= PF_W'(flits - FLIT_W'(1)) * PF_W'(cfg.body);
    m_hop_r  <= hop_r[L-1];
    m_flit_r <= flits;
  end

  // sum and result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= m_vld_r;
  end

  always_ff @(posedge clk) begin
    out_latency_cycles <= LAT_W'(m_ph_r) + LAT_W'(m_pf_r);
    out_hop_count      <= m_hop_r;
    out_flit_count     <= m_flit_r;
  end

endmodule

[hdl/noc_packet_latency_estimator.sv]
// Top level of the zero-load packet latency estimator: configuration registers,
// front end, queue and back end. Depends on nple_pkg, nple_front, nple_queue, nple_back.
//
//   channel   ports                                     handshake
//   input     in_source_node in_dest_node in_size_bytes  start && !busy
//             in_is_reply
//   result    out_latency_cycles out_hop_count           out_valid, one cycle
//             out_flit_count
//   config    cfg_index cfg_wdata                        cfg_we
//
// One packet per cycle while busy is low. A taken packet passes the queue register, then
// D = max(MAX_DIMS*ceil(min(NODE_ID_BITS,16)/4), 6) divider stages (16 at defaults), then the
// multiply and result registers. D is the longer divider chain, radix or flit, with four
// quotient bits per stage. busy is high only while the queue is full; the back end drains
// one entry a cycle. Synchronous reset clears the registers to their defaults and drops items in flight.
module noc_packet_latency_estimator import nple_pkg::*; #(
  parameter int MAX_DIMS     = 4,
  parameter int NODE_ID_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [NODE_W-1:0]     in_source_node,
  input  logic [NODE_W-1:0]     in_dest_node,
  input  logic [SIZE_W-1:0]     in_size_bytes,
  input  logic                  in_is_reply,
  output logic                  out_valid,
  output logic [LAT_W-1:0]      out_latency_cycles,
  output logic [HOP_W-1:0]      out_hop_count,
  output logic [FLIT_W-1:0]     out_flit_count,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [TOPO_W-1:0] topo_r;
  logic [RAD_W-1:0]  radix_r;
  logic [DIM_W-1:0]  dims_r;
  logic [DLY_W-1:0]  rt_dly_r;
  logic [DLY_W-1:0]  vc_dly_r;
  logic [DLY_W-1:0]  sa_dly_r;
  logic [STD_W-1:0]  st_dly_r;
  logic [FB_W-1:0]   fb_r;

  cfg_t  cfg;
  item_t item;
  item_t head;
  logic  push;
  logic  empty;
  logic  full;
  logic  [BODY_W-1:0] body_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      topo_r   <= TOPO_MESH;
      radix_r  <= RAD_W'(4);
      dims_r   <= DIM_W'(2);
      rt_dly_r <= DLY_W'(1);
      vc_dly_r <= DLY_W'(1);
      sa_dly_r <= DLY_W'(1);
      st_dly_r <= STD_W'(1);
      fb_r     <= FB_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOPOLOGY_MODE: topo_r   <= cfg_wdata[TOPO_W-1:0];
        CFG_RADIX:         radix_r  <= cfg_wdata[RAD_W-1:0];
        CFG_DIMENSIONS:    dims_r   <= cfg_wdata[DIM_W-1:0];
        CFG_ROUTING_DLY:   rt_dly_r <= cfg_wdata[DLY_W-1:0];
        CFG_VC_ALLOC_DLY:  vc_dly_r <= cfg_wdata[DLY_W-1:0];
        CFG_SW_ALLOC_DLY:  sa_dly_r <= cfg_wdata[DLY_W-1:0];
        CFG_SW_TRAV_DLY:   st_dly_r <= cfg_wdata[STD_W-1:0];
        CFG_FLIT_BITS:     fb_r     <= cfg_wdata[FB_W-1:0];
        default:           ;
      endcase
    end
  end

  assign body_raw = BODY_W'(sa_dly_r) + BODY_W'(st_dly_r);

  always_comb begin
    cfg.topo    = topo_r;
    cfg.radix   = radix_r;
    cfg.dims    = dims_r;
    cfg.head_p1 = HEAD_W'(rt_dly_r) + HEAD_W'(vc_dly_r) + HEAD_W'(sa_dly_r)
                + HEAD_W'(st_dly_r) + HEAD_W'(1);
    cfg.body    = (body_raw == '0) ? BODY_W'(1) : body_raw;
    cfg.fb      = (fb_r == '0) ? FB_W'(1) : fb_r;
  end

  assign busy = full;

  nple_front #(
    .MAX_DIMS     (MAX_DIMS),
    .NODE_ID_BITS (NODE_ID_BITS)
  ) u_front (
    .start          (start),
    .full           (full),
    .in_source_node (in_source_node),
    .in_dest_node   (in_dest_node),
    .in_size_bytes  (in_size_bytes),
    .in_is_reply    (in_is_reply),
    .cfg            (cfg),
    .push           (push),
    .item           (item)
  );

  nple_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (item),
    .pop       (!empty),
    .empty     (empty),
    .full      (full),
    .head      (head)
  );

  nple_back #(
    .MAX_DIMS     (MAX_DIMS),
    .NODE_ID_BITS (NODE_ID_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (!empty),
    .in_item            (head),
    .cfg                (cfg),
    .out_valid          (out_valid),
    .out_latency_cycles (out_latency_cycles),
    .out_hop_count      (out_hop_count),
    .out_flit_count     (out_flit_count)
  );

endmodule

[hdl/nple_checker.sv]
// Port-level checks of the latency estimator, bound to the top level.
// Depends on nple_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nple_checker import nple_pkg::*; #(
  parameter int MAX_DIMS     = 4,
  parameter int NODE_ID_BITS = 16
) (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [LAT_W-1:0]  out_latency_cycles,
  input logic [HOP_W-1:0]  out_hop_count,
  input logic [FLIT_W-1:0] out_flit_count
);

  // edges from the accepting edge to the edge that takes the result
  localparam int PIPE = pipe_depth(MAX_DIMS, NODE_ID_BITS) + 3;

  `NPLE_ASSERT_NR(a_reset_quiet, clk, !rst_n |=> !out_valid, "result strobe after reset")
  `NPLE_ASSERT(a_result_has_item, clk, rst_n,
               out_valid |-> $past(start && !busy, PIPE), "result without accepted packet")
  `NPLE_ASSERT(a_flits_nonzero, clk, rst_n,
               out_valid |-> out_flit_count != '0, "zero flit count")
  `NPLE_ASSERT(a_lat_ge_hops, clk, rst_n,
               out_valid |-> out_latency_cycles >= LAT_W'(out_hop_count), "latency below hops")
  `NPLE_ASSERT(a_local_single, clk, rst_n,
               (out_valid && out_hop_count == '0 && out_flit_count == FLIT_W'(1))
               |-> out_latency_cycles == '0, "local single flit with nonzero latency")

endmodule

bind noc_packet_latency_estimator nple_checker #(
  .MAX_DIMS     (MAX_DIMS),
  .NODE_ID_BITS (NODE_ID_BITS)
) u_nple_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_latency_cycles (out_latency_cycles),
  .out_hop_count      (out_hop_count),
  .out_flit_count     (out_flit_count)
);
